// ----- hw/rtl/char_lcd_nibble_write_sequencer_core_assert.svh -----
// Assertion macros used by the port checker of the LCD write sequencer.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_CORE_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLNWS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define CLNWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/clnws_pkg.sv -----
// Shared types and constants of the LCD nibble write sequencer.
`default_nettype none

package clnws_pkg;

  // Default storage sizes
  localparam int TICK_WIDTH  = 8;
  localparam int QUEUE_DEPTH = 2;

  // Payload and configuration widths
  localparam int BYTE_W    = 8;
  localparam int NIBBLE_W  = 4;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CMD_TAIL    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_TAIL   = 2'd3;

  // Configuration reset values
  localparam logic [CFG_W-1:0] CFG_ENABLE_HIGH_RST = 8'd1;
  localparam logic [CFG_W-1:0] CFG_ENABLE_LOW_RST  = 8'd1;
  localparam logic [CFG_W-1:0] CFG_CMD_TAIL_RST    = 8'd2;
  localparam logic [CFG_W-1:0] CFG_DATA_TAIL_RST   = 8'd1;

  // Word class decided by the front end
  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_SEND       = 2'd1,
    OP_SEND_EMPTY = 2'd2
  } op_e;

  // One classified word as it travels through the queue
  typedef struct packed {
    op_e                op;
    logic               sel;
    logic [BYTE_W-1:0]  byte_val;
    logic [BYTE_W-1:0]  count;
  } entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/char_lcd_nibble_write_sequencer_core.sv -----
// Path: an accepted word passes the front register and the queue into the engine registers.
// Throughput: one word per cycle while the result side does not stall; the front register,
// the queue and the engine each hand over one word per cycle, and the engine updates phase
// and tick counter in a single step.
// Reset: asynchronous, active low; clears the queue, phase, counters, held byte and
// pins, and loads the timing registers with their defaults. No clearing pass.
`default_nettype none

module char_lcd_nibble_write_sequencer_core #(
  parameter int TICK_WIDTH  = clnws_pkg::TICK_WIDTH,
  parameter int QUEUE_DEPTH = clnws_pkg::QUEUE_DEPTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               req_type_i,
  input  wire logic                               register_select_i,
  input  wire logic [clnws_pkg::BYTE_W-1:0]       byte_value_i,
  input  wire logic [clnws_pkg::BYTE_W-1:0]       repeat_count_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [clnws_pkg::NIBBLE_W-1:0]          bus_nibble_o,
  output logic                                    rs_pin_o,
  output logic                                    en_pin_o,
  output logic                                    busy_res_o,
  output logic                                    rejected_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [clnws_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [clnws_pkg::CFG_W-1:0]        cfg_data_i
);

  logic              push_valid, push_ready;
  clnws_pkg::entry_t push_entry;
  logic              pop_valid, pop_ready;
  clnws_pkg::entry_t pop_entry;

  // Accept and classify words
  clnws_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .register_select_i (register_select_i),
    .byte_value_i      (byte_value_i),
    .repeat_count_i    (repeat_count_i),
    .push_valid_o      (push_valid),
    .push_ready_i      (push_ready),
    .push_entry_o      (push_entry)
  );

  // Decouple front and engine
  clnws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // Run the write sequence
  clnws_back #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_entry_i  (pop_entry),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .bus_nibble_o (bus_nibble_o),
    .rs_pin_o     (rs_pin_o),
    .en_pin_o     (en_pin_o),
    .busy_res_o   (busy_res_o),
    .rejected_o   (rejected_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/clnws_front.sv -----
// Front end: registers incoming words and classifies them for the queue.
`default_nettype none

module clnws_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          req_type_i,
  input  wire logic                          register_select_i,
  input  wire logic [clnws_pkg::BYTE_W-1:0]  byte_value_i,
  input  wire logic [clnws_pkg::BYTE_W-1:0]  repeat_count_i,
  output logic                               push_valid_o,
  input  wire logic                          push_ready_i,
  output clnws_pkg::entry_t                  push_entry_o
);

  logic              valid_q, valid_d;
  clnws_pkg::entry_t entry_q, entry_d;
  logic              load;

  // Accept when the stage is empty or drains this cycle
  assign in_ready_o = !valid_q || push_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // Classify the word: tick, send, or send with nothing to repeat
  always_comb begin
    entry_d          = entry_q;
    entry_d.sel      = register_select_i;
    entry_d.byte_val = byte_value_i;
    entry_d.count    = repeat_count_i;
    if (!req_type_i) begin
      entry_d.op = clnws_pkg::OP_TICK;
    end else if (repeat_count_i == '0) begin
      entry_d.op = clnws_pkg::OP_SEND_EMPTY;
    end else begin
      entry_d.op = clnws_pkg::OP_SEND;
    end
  end

  // Hold until the queue takes the word
  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      entry_q <= entry_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_entry_o = entry_q;

endmodule

`default_nettype wire

// ----- hw/rtl/clnws_queue.sv -----
// Short register queue between the front end and the write engine.
`default_nettype none

module clnws_queue #(
  parameter int DEPTH = clnws_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_valid_i,
  output logic                    push_ready_o,
  input  clnws_pkg::entry_t       push_entry_i,
  output logic                    pop_valid_o,
  input  wire logic               pop_ready_i,
  output clnws_pkg::entry_t       pop_entry_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  clnws_pkg::entry_t mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/clnws_back.sv -----
// Write engine: steps the nibble sequence and registers the pin levels.
`default_nettype none

module clnws_back #(
  parameter int TICK_WIDTH = clnws_pkg::TICK_WIDTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               pop_valid_i,
  output logic                                    pop_ready_o,
  input  clnws_pkg::entry_t                       pop_entry_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [clnws_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [clnws_pkg::CFG_W-1:0]        cfg_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [clnws_pkg::NIBBLE_W-1:0]          bus_nibble_o,
  output logic                                    rs_pin_o,
  output logic                                    en_pin_o,
  output logic                                    busy_res_o,
  output logic                                    rejected_o
);

  localparam int BW = clnws_pkg::BYTE_W;
  localparam int NW = clnws_pkg::NIBBLE_W;
  localparam int FW = clnws_pkg::CFG_W;
  // Compare width covers both the counter carry and the limit
  localparam int CW = (TICK_WIDTH + 1 > FW) ? TICK_WIDTH + 1 : FW;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_HIGH_EN  = 3'd1;
  localparam logic [2:0] PH_HIGH_GAP = 3'd2;
  localparam logic [2:0] PH_LOW_EN   = 3'd3;
  localparam logic [2:0] PH_TAIL     = 3'd4;

  localparam logic [BW-1:0] HIGH_MASK = 8'hF0;
  localparam logic [BW-1:0] LOW_MASK  = 8'h0F;

  logic [FW-1:0]         en_high_q, en_low_q, cmd_tail_q, data_tail_q;
  logic [2:0]            phase_q, phase_d;
  logic [TICK_WIDTH-1:0] tick_q, tick_d;
  logic [BW-1:0]         byte_q, byte_d;
  logic                  sel_q, sel_d;
  logic [BW-1:0]         reps_q, reps_d;
  logic [NW-1:0]         nib_q, nib_d;
  logic                  en_q, en_d;
  logic                  rej_q, rej_d;
  logic                  out_valid_q, out_valid_d;

  logic                  take;
  logic                  busy;
  logic [FW-1:0]         limit;
  logic [TICK_WIDTH:0]   next_cnt;
  logic                  done;
  logic [BW-1:0]         reps_dec;
  logic [BW-1:0]         hi_byte, lo_byte;

  // Take a word when the result register is free or drains this cycle
  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign take        = pop_valid_i && pop_ready_o;

  assign busy = (phase_q >= PH_HIGH_EN) && (phase_q <= PH_TAIL);

  // Pick the length of the current phase
  always_comb begin
    case (phase_q)
      PH_HIGH_GAP: limit = en_low_q;
      PH_TAIL:     limit = sel_q ? data_tail_q : cmd_tail_q;
      default:     limit = en_high_q;
    endcase
  end

  // Phase ends at the limit or when the counter would overflow
  assign next_cnt = {1'b0, tick_q} + 1'b1;
  assign done     = (CW'(next_cnt) >= CW'(limit)) || next_cnt[TICK_WIDTH];

  assign reps_dec = (reps_q != '0) ? reps_q - 1'b1 : reps_q;
  assign hi_byte  = (byte_q & HIGH_MASK) >> NW;
  assign lo_byte  = byte_q & LOW_MASK;

  // Step the sequence for one word
  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    byte_d  = byte_q;
    sel_d   = sel_q;
    reps_d  = reps_q;
    nib_d   = nib_q;
    en_d    = en_q;
    rej_d   = rej_q;
    if (take) begin
      rej_d = 1'b0;
      unique case (pop_entry_i.op)
        clnws_pkg::OP_TICK: begin
          unique case (phase_q)
            PH_HIGH_EN: begin
              if (done) begin
                tick_d  = '0;
                en_d    = 1'b0;
                phase_d = PH_HIGH_GAP;
              end else begin
                tick_d = next_cnt[TICK_WIDTH-1:0];
              end
            end
            PH_HIGH_GAP: begin
              if (done) begin
                tick_d  = '0;
                nib_d   = lo_byte[NW-1:0];
                en_d    = 1'b1;
                phase_d = PH_LOW_EN;
              end else begin
                tick_d = next_cnt[TICK_WIDTH-1:0];
              end
            end
            PH_LOW_EN: begin
              if (done) begin
                tick_d  = '0;
                en_d    = 1'b0;
                phase_d = PH_TAIL;
              end else begin
                tick_d = next_cnt[TICK_WIDTH-1:0];
              end
            end
            PH_TAIL: begin
              if (done) begin
                tick_d = '0;
                reps_d = reps_dec;
                if (reps_dec != '0) begin
                  nib_d   = hi_byte[NW-1:0];
                  en_d    = 1'b1;
                  phase_d = PH_HIGH_EN;
                end else begin
                  en_d    = 1'b0;
                  phase_d = PH_IDLE;
                end
              end else begin
                tick_d = next_cnt[TICK_WIDTH-1:0];
              end
            end
            default: begin
              phase_d = PH_IDLE;
              en_d    = 1'b0;
              tick_d  = '0;
            end
          endcase
        end
        clnws_pkg::OP_SEND: begin
          if (busy) begin
            rej_d = 1'b1;
          end else begin
            byte_d  = pop_entry_i.byte_val;
            sel_d   = pop_entry_i.sel;
            reps_d  = pop_entry_i.count;
            nib_d   = pop_entry_i.byte_val[BW-1:BW-NW];
            en_d    = 1'b1;
            phase_d = PH_HIGH_EN;
            tick_d  = '0;
          end
        end
        clnws_pkg::OP_SEND_EMPTY: begin
          rej_d = busy;
        end
        default: begin
          rej_d = 1'b0;
        end
      endcase
    end
  end

  // Hold the result until the consumer takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      byte_q      <= '0;
      sel_q       <= 1'b0;
      reps_q      <= '0;
      nib_q       <= '0;
      en_q        <= 1'b0;
      rej_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      byte_q      <= byte_d;
      sel_q       <= sel_d;
      reps_q      <= reps_d;
      nib_q       <= nib_d;
      en_q        <= en_d;
      rej_q       <= rej_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_high_q   <= clnws_pkg::CFG_ENABLE_HIGH_RST;
      en_low_q    <= clnws_pkg::CFG_ENABLE_LOW_RST;
      cmd_tail_q  <= clnws_pkg::CFG_CMD_TAIL_RST;
      data_tail_q <= clnws_pkg::CFG_DATA_TAIL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        clnws_pkg::CFG_ENABLE_HIGH: en_high_q   <= cfg_data_i;
        clnws_pkg::CFG_ENABLE_LOW:  en_low_q    <= cfg_data_i;
        clnws_pkg::CFG_CMD_TAIL:    cmd_tail_q  <= cfg_data_i;
        clnws_pkg::CFG_DATA_TAIL:   data_tail_q <= cfg_data_i;
        default:                    en_high_q   <= en_high_q;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign bus_nibble_o = nib_q;
  assign rs_pin_o     = sel_q;
  assign en_pin_o     = en_q;
  assign busy_res_o   = busy;
  assign rejected_o   = rej_q;

endmodule

`default_nettype wire

// ----- hw/rtl/clnws_port_check.sv -----
// Port-level checker for the LCD write sequencer, bound to the top level.
`default_nettype none
`include "char_lcd_nibble_write_sequencer_core_assert.svh"

module clnws_port_check (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [clnws_pkg::NIBBLE_W-1:0] bus_nibble_i,
  input wire logic                          rs_pin_i,
  input wire logic                          en_pin_i,
  input wire logic                          busy_res_i,
  input wire logic                          rejected_i
);

  logic                            out_stall;
  logic [clnws_pkg::NIBBLE_W+2:0]  out_word;

  assign out_stall = out_valid_i && !out_ready_i;
  assign out_word  = {bus_nibble_i, rs_pin_i, en_pin_i, rejected_i};

  // Stalled result word keeps valid and payload
  `CLNWS_ASSERT_NEXT(a_out_hold_valid, clk_i, rst_ni, out_stall, out_valid_i)
  `CLNWS_ASSERT_NEXT(a_out_hold_data, clk_i, rst_ni, out_stall, $stable(out_word))

  // A dropped send leaves the sequence running
  `CLNWS_ASSERT_IMPLY(a_reject_busy, clk_i, rst_ni, out_valid_i && rejected_i, busy_res_i)

  // Enable strobes only inside a write sequence
  `CLNWS_ASSERT_IMPLY(a_enable_busy, clk_i, rst_ni, out_valid_i && en_pin_i, busy_res_i)

endmodule

bind char_lcd_nibble_write_sequencer_core clnws_port_check u_port_check (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .bus_nibble_i (bus_nibble_o),
  .rs_pin_i     (rs_pin_o),
  .en_pin_i     (en_pin_o),
  .busy_res_i   (busy_res_o),
  .rejected_i   (rejected_o)
);

`default_nettype wire

// ----- tb/sv/char_lcd_nibble_write_sequencer_core_checker.sv -----
// Pin-level predictor and result checker for the LCD nibble write sequencer.
`timescale 1ns / 1ps

module char_lcd_nibble_write_sequencer_core_checker #(
  parameter int TICK_W = clnws_pkg::TICK_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic                              req_type_i,
  input  logic                              register_select_i,
  input  logic [clnws_pkg::BYTE_W-1:0]      byte_value_i,
  input  logic [clnws_pkg::BYTE_W-1:0]      repeat_count_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [clnws_pkg::NIBBLE_W-1:0]    bus_nibble_i,
  input  logic                              rs_pin_i,
  input  logic                              en_pin_i,
  input  logic                              busy_res_i,
  input  logic                              rejected_i,
  input  logic                              cfg_we_i,
  input  logic [clnws_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [clnws_pkg::CFG_W-1:0]       cfg_data_i,
  output int                                pending_o,
  output int                                fail_count_o
);

  localparam int NW = clnws_pkg::NIBBLE_W;
  localparam int BW = clnws_pkg::BYTE_W;
  localparam int FW = clnws_pkg::CFG_W;

  typedef enum logic [2:0] {
    SEQ_IDLE     = 3'd0,
    SEQ_HIGH_EN  = 3'd1,
    SEQ_HIGH_GAP = 3'd2,
    SEQ_LOW_EN   = 3'd3,
    SEQ_TAIL     = 3'd4
  } seq_phase_e;

  typedef struct packed {
    logic [NW-1:0] nibble;
    logic          rs;
    logic          en;
    logic          busy;
    logic          rej;
  } pin_levels_t;

  // Timing registers as the block should hold them
  logic [FW-1:0]       en_high_t, en_low_t, cmd_tail_t, data_tail_t;

  // Sequencer state
  seq_phase_e          seq_phase;
  logic [TICK_W-1:0]   tick_cnt;
  logic [BW-1:0]       held_byte;
  logic [BW-1:0]       held_reps;
  logic                held_sel;
  logic [NW-1:0]       lines;
  logic                strobe;

  // Pin levels expected for accepted words, oldest first
  pin_levels_t         pin_levels_q[$];

  // Print one line per mismatch and count it
  task automatic report_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic logic seq_busy();
    return (seq_phase >= SEQ_HIGH_EN) && (seq_phase <= SEQ_TAIL);
  endfunction

  // Present the high nibble with enable raised and restart the wait
  function automatic void load_high_nibble();
    lines     = held_byte[7:4];
    strobe    = 1'b1;
    seq_phase = SEQ_HIGH_EN;
    tick_cnt  = '0;
  endfunction

  // Advance the tick counter; true once the wait of this length is over
  function automatic logic wait_over(input logic [FW-1:0] limit);
    int nxt;
    nxt = int'(tick_cnt) + 1;
    if ((nxt >= int'(limit)) || (nxt > (1 << TICK_W) - 1)) begin
      tick_cnt = '0;
      return 1'b1;
    end
    tick_cnt = nxt[TICK_W-1:0];
    return 1'b0;
  endfunction

  // Apply one word to the state and return the pin levels after it
  function automatic pin_levels_t predict_pins(input clnws_pkg::op_e op, input logic sel,
                                               input logic [BW-1:0] byte_v,
                                               input logic [BW-1:0] reps);
    pin_levels_t p;
    logic        rej;
    rej = 1'b0;
    if (op == clnws_pkg::OP_SEND) begin
      // drop a send while busy; a zero count changes nothing
      if (seq_busy()) begin
        rej = 1'b1;
      end else if (reps != '0) begin
        held_byte = byte_v;
        held_sel  = sel;
        held_reps = reps;
        load_high_nibble();
      end
    end else begin
      case (seq_phase)
        SEQ_HIGH_EN: begin
          if (wait_over(en_high_t)) begin
            strobe    = 1'b0;
            seq_phase = SEQ_HIGH_GAP;
          end
        end
        SEQ_HIGH_GAP: begin
          if (wait_over(en_low_t)) begin
            lines     = held_byte[3:0];
            strobe    = 1'b1;
            seq_phase = SEQ_LOW_EN;
          end
        end
        SEQ_LOW_EN: begin
          if (wait_over(en_high_t)) begin
            strobe    = 1'b0;
            seq_phase = SEQ_TAIL;
          end
        end
        SEQ_TAIL: begin
          // tail length follows the register select of the held byte
          if (wait_over(held_sel ? data_tail_t : cmd_tail_t)) begin
            if (held_reps != '0) held_reps = held_reps - 1'b1;
            if (held_reps != '0) begin
              load_high_nibble();
            end else begin
              seq_phase = SEQ_IDLE;
              strobe    = 1'b0;
            end
          end
        end
        default: begin
          seq_phase = SEQ_IDLE;
          strobe    = 1'b0;
          tick_cnt  = '0;
        end
      endcase
    end
    p.nibble = lines;
    p.rs     = held_sel;
    p.en     = strobe;
    p.busy   = seq_busy();
    p.rej    = rej;
    return p;
  endfunction

  // Track register writes, predict accepted words and compare result words
  always @(posedge clk_i or negedge rst_ni) begin
    pin_levels_t    want;
    clnws_pkg::op_e op;
    if (!rst_ni) begin
      en_high_t    = clnws_pkg::CFG_ENABLE_HIGH_RST;
      en_low_t     = clnws_pkg::CFG_ENABLE_LOW_RST;
      cmd_tail_t   = clnws_pkg::CFG_CMD_TAIL_RST;
      data_tail_t  = clnws_pkg::CFG_DATA_TAIL_RST;
      seq_phase    = SEQ_IDLE;
      tick_cnt     = '0;
      held_byte    = '0;
      held_reps    = '0;
      held_sel     = 1'b0;
      lines        = '0;
      strobe       = 1'b0;
      pin_levels_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          clnws_pkg::CFG_ENABLE_HIGH: en_high_t   = cfg_data_i;
          clnws_pkg::CFG_ENABLE_LOW:  en_low_t    = cfg_data_i;
          clnws_pkg::CFG_CMD_TAIL:    cmd_tail_t  = cfg_data_i;
          clnws_pkg::CFG_DATA_TAIL:   data_tail_t = cfg_data_i;
          default: ;
        endcase
      end

      // retire the result first so a word accepted now never matches it
      if (out_valid_i && out_ready_i) begin
        if (pin_levels_q.size() == 0) begin
          report_error("result word with no expectation waiting");
        end else begin
          want = pin_levels_q.pop_front();
          if (bus_nibble_i !== want.nibble)
            report_error($sformatf("bus_nibble got %h want %h", bus_nibble_i, want.nibble));
          if (rs_pin_i !== want.rs)
            report_error($sformatf("rs_pin got %b want %b", rs_pin_i, want.rs));
          if (en_pin_i !== want.en)
            report_error($sformatf("en_pin got %b want %b", en_pin_i, want.en));
          if (busy_res_i !== want.busy)
            report_error($sformatf("busy_res got %b want %b", busy_res_i, want.busy));
          if (rejected_i !== want.rej)
            report_error($sformatf("rejected got %b want %b", rejected_i, want.rej));
        end
      end

      if (in_valid_i && in_ready_i) begin
        op = req_type_i ? clnws_pkg::OP_SEND : clnws_pkg::OP_TICK;
        pin_levels_q.push_back(predict_pins(op, register_select_i, byte_value_i,
                                            repeat_count_i));
      end
      pending_o = pin_levels_q.size();
    end
  end

endmodule

// ----- tb/sv/char_lcd_nibble_write_sequencer_core_tb.sv -----
// Stimulus, handshake pacing and verdict for the LCD nibble write sequencer.
`timescale 1ns / 1ps

module char_lcd_nibble_write_sequencer_core_tb;

  localparam int   BW           = clnws_pkg::BYTE_W;
  localparam int   NW           = clnws_pkg::NIBBLE_W;
  localparam int   IW           = clnws_pkg::CFG_IDX_W;
  localparam int   FW           = clnws_pkg::CFG_W;
  localparam int   STALL_LIMIT  = 2000;
  localparam int   DRAIN_CYCLES = 10;
  localparam logic SEL_CMD      = 1'b0;
  localparam logic SEL_DATA     = 1'b1;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic                 req_type   = 1'b0;
  logic                 reg_sel    = 1'b0;
  logic [BW-1:0]        byte_val   = '0;
  logic [BW-1:0]        rep_cnt    = '0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic [NW-1:0]        bus_nibble;
  logic                 rs_pin;
  logic                 en_pin;
  logic                 busy_res;
  logic                 rejected;
  logic                 cfg_we     = 1'b0;
  logic [IW-1:0]        cfg_index  = '0;
  logic [FW-1:0]        cfg_data   = '0;

  int pending_words;
  int mismatches;
  int stall_cycles = 0;
  int calm_words   = 0;

  // Timing in effect, in ticks per wait (a zero register acts as one tick)
  int t_high = int'(clnws_pkg::CFG_ENABLE_HIGH_RST);
  int t_low  = int'(clnws_pkg::CFG_ENABLE_LOW_RST);
  int t_cmd  = int'(clnws_pkg::CFG_CMD_TAIL_RST);
  int t_data = int'(clnws_pkg::CFG_DATA_TAIL_RST);

  char_lcd_nibble_write_sequencer_core dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .req_type_i        (req_type),
    .register_select_i (reg_sel),
    .byte_value_i      (byte_val),
    .repeat_count_i    (rep_cnt),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .bus_nibble_o      (bus_nibble),
    .rs_pin_o          (rs_pin),
    .en_pin_o          (en_pin),
    .busy_res_o        (busy_res),
    .rejected_o        (rejected),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  char_lcd_nibble_write_sequencer_core_checker pin_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .req_type_i        (req_type),
    .register_select_i (reg_sel),
    .byte_value_i      (byte_val),
    .repeat_count_i    (rep_cnt),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .bus_nibble_i      (bus_nibble),
    .rs_pin_i          (rs_pin),
    .en_pin_i          (en_pin),
    .busy_res_i        (busy_res),
    .rejected_i        (rejected),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .pending_o         (pending_words),
    .fail_count_o      (mismatches)
  );

  always #5 clk = ~clk;

  // Mostly short idle gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic push_word(input clnws_pkg::op_e op, input logic sel,
                           input logic [BW-1:0] b, input logic [BW-1:0] c);
    int gap;
    gap = idle_len();
    if (calm_words > 0) begin
      calm_words--;
      gap = 0;
    end else if ($urandom_range(0, 63) == 0) begin
      calm_words = $urandom_range(20, 120);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= (op == clnws_pkg::OP_SEND);
    reg_sel  <= sel;
    byte_val <= b;
    rep_cnt  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // A tick carries random don't-care fields
  task automatic push_tick();
    push_word(clnws_pkg::OP_TICK, 1'($urandom_range(0, 1)), BW'($urandom()),
              BW'($urandom()));
  endtask

  // Drop valid and wait until every expected word has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_words != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Write all four timing registers, one per cycle
  task automatic write_timing(input int h, input int l, input int c, input int d);
    cfg_we    <= 1'b1;
    cfg_index <= clnws_pkg::CFG_ENABLE_HIGH;
    cfg_data  <= h[FW-1:0];
    @(posedge clk);
    cfg_index <= clnws_pkg::CFG_ENABLE_LOW;
    cfg_data  <= l[FW-1:0];
    @(posedge clk);
    cfg_index <= clnws_pkg::CFG_CMD_TAIL;
    cfg_data  <= c[FW-1:0];
    @(posedge clk);
    cfg_index <= clnws_pkg::CFG_DATA_TAIL;
    cfg_data  <= d[FW-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    t_high = (h == 0) ? 1 : h;
    t_low  = (l == 0) ? 1 : l;
    t_cmd  = (c == 0) ? 1 : c;
    t_data = (d == 0) ? 1 : d;
  endtask

  // Send a byte, then tick it through every repeat plus a few idle ticks;
  // stray sends land only while the sequence is still running
  task automatic send_train(input logic sel, input logic [BW-1:0] b,
                            input logic [BW-1:0] reps, input int noise_pct);
    int per_byte;
    int needed;
    int extra;
    per_byte = 2 * t_high + t_low + (sel ? t_data : t_cmd);
    needed   = int'(reps) * per_byte;
    extra    = $urandom_range(0, 2);
    push_word(clnws_pkg::OP_SEND, sel, b, reps);
    for (int i = 0; i < needed + extra; i++) begin
      if ((i < needed) && ($urandom_range(0, 99) < noise_pct))
        push_word(clnws_pkg::OP_SEND, 1'($urandom_range(0, 1)), BW'($urandom()),
                  BW'($urandom()));
      push_tick();
    end
  endtask

  // Random byte trains with small repeat counts, a few empty sends and stray ticks
  task automatic random_trains(input int trains, input int max_reps);
    logic          sel;
    logic [BW-1:0] b;
    int            reps;
    repeat (trains) begin
      sel  = 1'($urandom_range(0, 1));
      b    = BW'($urandom());
      reps = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, max_reps);
      send_train(sel, b, reps[BW-1:0], 8);
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 4)) push_tick();
    end
    wait_for_results();
  endtask

  // Pace the result side: random stalls between runs of ready
  initial begin : ready_gen
    int gap;
    int run;
    @(posedge clk);
    forever begin
      gap = idle_len();
      run = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
    end
  end

  // Count cycles in which neither side moves a word
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle tick, empty send, command with a send dropped mid-way, data x2
    push_tick();
    push_word(clnws_pkg::OP_SEND, SEL_DATA, 8'hA5, 8'd0);
    push_word(clnws_pkg::OP_SEND, SEL_CMD, 8'hF0, 8'd1);
    repeat (2) push_tick();
    push_word(clnws_pkg::OP_SEND, SEL_DATA, 8'h0F, 8'hFF);
    repeat (4) push_tick();
    send_train(SEL_DATA, 8'h0F, 8'd2, 0);
    wait_for_results();

    // Zero registers act as one tick; also a long repeat count
    write_timing(0, 0, 0, 0);
    random_trains(10, 4);
    send_train(1'($urandom_range(0, 1)), BW'($urandom()), 8'd20, 2);
    wait_for_results();

    write_timing($urandom_range(1, 4), $urandom_range(1, 4),
                 $urandom_range(1, 4), $urandom_range(1, 4));
    random_trains(6, 3);

    write_timing($urandom_range(0, 8), $urandom_range(0, 8),
                 $urandom_range(0, 8), $urandom_range(0, 8));
    random_trains(5, 3);

    // Long enable and data tail waits
    write_timing(40, 40, 1, 40);
    send_train(SEL_DATA, BW'($urandom()), 8'd1, 1);
    wait_for_results();

    // Longest command tail
    write_timing(1, 1, 255, 1);
    send_train(SEL_CMD, BW'($urandom()), 8'd1, 2);
    random_trains(1, 1);

    write_timing($urandom_range(2, 6), $urandom_range(2, 6),
                 $urandom_range(2, 6), $urandom_range(2, 6));
    random_trains(5, 3);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if ((mismatches == 0) && (pending_words == 0)) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
